/* rtl/hcbd_pkg.sv */
// hcbd_pkg: types and constants for the HTTP chunked body decoder.
// No dependencies; imported by http_chunked_body_decoder_unit.
`timescale 1ns / 1ps

package hcbd_pkg;

  // Keeping this many size-line characters is a framing fault
  localparam int unsigned SIZE_LINE_LIMIT = 8;
  localparam int unsigned KEPT_W          = $clog2(SIZE_LINE_LIMIT + 1);

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SIZE_W  = 28;

  localparam logic [SIZE_W-1:0] VALUE_MAX = 28'h0FF_FFFF | 28'hF00_0000;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [KEPT_W-1:0] kept_t;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_REST    = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CR      = 3'd3,
    PH_LF      = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_t;

  // Size-line parser state after one kept character
  typedef struct packed {
    kept_t kept;
    size_t value;
    logic  stopped;
  } size_line_t;

  // Hex digit decode: valid flag and nibble
  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

endpackage

/* rtl/http_chunked_body_decoder_unit.sv */
// http_chunked_body_decoder_unit: byte-wide HTTP chunked transfer decoder.
// Depends on hcbd_pkg (phase enum, size-line struct, character constants).
`timescale 1ns / 1ps

// ---------------------------------------------------------------------------
// Usage
//  - Input channel: in_byte with in_valid/in_ready. One raw body byte a word.
//  - Result channel: out_byte, out_valid, out_body_end, out_framing_error with
//    out_word_valid/out_word_ready. Every accepted input byte yields exactly
//    one result word; out_valid flags whether out_byte carries payload.
//  - cfg_we/cfg_wdata write chunked_enable (1 = decode, 0 = pass-through).
//    Write only while idle.
//  - Latency: result word appears the cycle after the input is accepted.
//  - Throughput: one byte per clock. The parser state updates at the accept
//    edge and the result lands in a single output register; in_ready stays
//    high while that register is empty or being drained the same cycle.
//  - Receiver stall: the output word holds, in_ready drops until it is taken;
//    no word is lost or repeated.
//  - Reset (rst_n low, synchronous): pass-through mode, parser at the first
//    size-line character, output register empty (its flags are not cleared).
//  - body_end and framing_error are sticky until reset; once either is set
//    further chunked bytes are swallowed (out_valid 0).
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_unit (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  hcbd_pkg::byte_t    in_byte,
  // result channel
  output logic               out_word_valid,
  input  logic               out_word_ready,
  output hcbd_pkg::byte_t    out_byte,
  output logic               out_valid,
  output logic               out_body_end,
  output logic               out_framing_error
);
  import hcbd_pkg::*;

  function automatic hex_t hex_digit(input byte_t c);
    hex_t h;
    h.ok  = 1'b0;
    h.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.nib = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.nib = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.nib = 4'(c - 8'h61 + 8'd10);
    end
    return h;
  endfunction

  // Keep one size-line character: count it, fold it into the value
  // unless the hex run has already stopped. Saturates on overflow.
  function automatic size_line_t keep_char(input size_line_t s, input byte_t c);
    size_line_t r;
    hex_t       h;
    r      = s;
    h      = hex_digit(c);
    r.kept = s.kept + kept_t'(1);
    if (!s.stopped) begin
      if (!h.ok) begin
        r.stopped = 1'b1;
      end else if (s.value[SIZE_W-1 -: 4] != 4'd0) begin
        r.value = VALUE_MAX;
      end else begin
        r.value = {s.value[SIZE_W-5:0], h.nib};
      end
    end
    return r;
  endfunction

  // configuration
  logic       chunked_enable_r;

  // parser state
  phase_t     phase_r,      phase_nxt;
  size_line_t line_r,       line_nxt;
  size_t      bytes_left_r, bytes_left_nxt;

  // output register
  logic       out_word_valid_r;
  byte_t      out_byte_r,   out_byte_nxt;
  logic       out_valid_r,  out_valid_nxt;
  logic       body_end_r,   body_end_nxt;
  logic       frm_err_r,    frm_err_nxt;

  logic       in_acc;
  size_line_t kept_s;
  size_t      left_dec;

  assign in_ready = !out_word_valid_r || out_word_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunked_enable_r <= 1'b0;
    end else if (cfg_we) begin
      chunked_enable_r <= cfg_wdata;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      line_r       <= '0;
      bytes_left_r <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      line_r       <= line_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // next state and result word
  always_comb begin
    phase_nxt      = phase_r;
    line_nxt       = line_r;
    bytes_left_nxt = bytes_left_r;
    out_byte_nxt   = '0;
    out_valid_nxt  = 1'b0;
    kept_s         = keep_char(line_r, in_byte);
    left_dec       = (bytes_left_r != '0) ? bytes_left_r - size_t'(1) : bytes_left_r;

    if (!chunked_enable_r) begin
      // pass-through: parser frozen
      out_byte_nxt  = in_byte;
      out_valid_nxt = 1'b1;
    end else begin
      unique case (phase_r)
        PH_FIRST: begin
          // first character always kept, fresh line
          line_nxt  = keep_char('0, in_byte);
          phase_nxt = PH_REST;
        end
        PH_REST: begin
          if (in_byte == CH_LF) begin
            if (line_r.value == '0) begin
              phase_nxt = PH_DONE;
            end else begin
              bytes_left_nxt = line_r.value;
              phase_nxt      = PH_PAYLOAD;
            end
          end else if (in_byte != CH_CR) begin
            line_nxt = kept_s;
            if (kept_s.kept >= kept_t'(SIZE_LINE_LIMIT)) phase_nxt = PH_ERROR;
          end
        end
        PH_PAYLOAD: begin
          out_byte_nxt   = in_byte;
          out_valid_nxt  = 1'b1;
          bytes_left_nxt = left_dec;
          if (left_dec == '0) phase_nxt = PH_CR;
        end
        PH_CR: begin
          phase_nxt = (in_byte == CH_CR) ? PH_LF : PH_ERROR;
        end
        PH_LF: begin
          phase_nxt = (in_byte == CH_LF) ? PH_FIRST : PH_ERROR;
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_ERROR;
        end
      endcase
    end

    body_end_nxt = (phase_nxt == PH_DONE);
    frm_err_nxt  = (phase_nxt == PH_ERROR);
  end

  // result register: loads on accept, empties when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_word_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_word_valid_r <= 1'b1;
    end else if (out_word_ready) begin
      out_word_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_byte_r  <= out_byte_nxt;
      out_valid_r <= out_valid_nxt;
      body_end_r  <= body_end_nxt;
      frm_err_r   <= frm_err_nxt;
    end
  end

  assign out_word_valid    = out_word_valid_r;
  assign out_byte          = out_byte_r;
  assign out_valid         = out_valid_r;
  assign out_body_end      = body_end_r;
  assign out_framing_error = frm_err_r;

endmodule
